>>> src/k_times_admission_counter_assert.svh
// Assertion macros shared by the checker of the K-times admission counter.
`ifndef K_TIMES_ADMISSION_COUNTER_ASSERT_SVH
`define K_TIMES_ADMISSION_COUNTER_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define KTAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is held.
`define KTAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define KTAC_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/kac_pkg.sv
// Package with the types and constants of the K-times admission counter.
package kac_pkg;

    localparam int ENTRIES    = 64;
    localparam int DESC_BITS  = 32;
    localparam int ENTRY_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_BITS  = $clog2(ENTRIES + 1);
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] K_RESET   = COUNT_BITS'(2);

    typedef struct packed {
        logic [63:0] desc_hash;
        logic [31:0] desc_id;
    } t_in_item;

    typedef struct packed {
        logic                  reached_k;
        logic                  was_new;
        logic                  table_full;
        logic [COUNT_BITS-1:0] sightings;
    } t_out_item;

    // Key as it is compared and stored in the table.
    typedef struct packed {
        logic [63:0]          hash;
        logic [DESC_BITS-1:0] desc;
    } t_key;

    // Lookup outcome handed from the table to the result logic.
    typedef struct packed {
        logic                  hit;
        logic                  full;
        logic [COUNT_BITS-1:0] count;
    } t_lookup;

    function automatic logic [DESC_BITS-1:0] desc_key(input logic [31:0] d);
        logic [63:0] w;
        w = 64'(d);
        return w[DESC_BITS-1:0];
    endfunction

endpackage

>>> src/kac_entry.sv
// One table entry: stored pair, its count, and its own comparator.
module kac_entry (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_alloc,
    input  kac_pkg::t_key                i_key,
    output logic                         o_match,
    output logic [kac_pkg::COUNT_BITS-1:0] o_count
);

    logic                           r_valid;
    kac_pkg::t_key                  r_key;
    logic [kac_pkg::COUNT_BITS-1:0] r_count;
    logic [kac_pkg::COUNT_BITS-1:0] n_count;

    assign o_match = r_valid && (r_key == i_key);
    assign n_count = (r_count == kac_pkg::COUNT_MAX) ? r_count
                                                     : r_count + kac_pkg::COUNT_ONE;
    assign o_count = o_match ? n_count : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en && i_alloc) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_alloc) begin
            r_key   <= i_key;
            r_count <= kac_pkg::COUNT_ONE;
        end else if (i_en && o_match) begin
            r_count <= n_count;
        end
    end

endmodule

>>> src/kac_lookup.sv
// Associative table: parallel match over all entries and in-order allocation.
module kac_lookup (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  kac_pkg::t_key    i_key,
    output kac_pkg::t_lookup o_res
);

    logic [kac_pkg::FILL_BITS-1:0]  r_fill;
    logic [kac_pkg::ENTRIES-1:0]    match;
    logic [kac_pkg::ENTRIES-1:0]    alloc;
    logic [kac_pkg::COUNT_BITS-1:0] counts [kac_pkg::ENTRIES];
    logic [kac_pkg::COUNT_BITS-1:0] count_or;
    logic                           hit;
    logic                           full;

    assign hit  = |match;
    assign full = (r_fill == kac_pkg::FILL_BITS'(kac_pkg::ENTRIES));

    for (genvar g = 0; g < kac_pkg::ENTRIES; g++) begin : g_entry
        assign alloc[g] = !hit && !full &&
                          (r_fill[kac_pkg::ENTRY_BITS-1:0] == kac_pkg::ENTRY_BITS'(g));
        kac_entry u_entry (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_alloc (alloc[g]),
            .i_key   (i_key),
            .o_match (match[g]),
            .o_count (counts[g])
        );
    end

    // Only the matching entry drives a nonzero count.
    always_comb begin
        count_or = '0;
        for (int e = 0; e < kac_pkg::ENTRIES; e++) begin
            count_or = count_or | counts[e];
        end
    end

    assign o_res = '{hit: hit, full: full, count: count_or};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_en && !hit && !full) begin
            r_fill <= r_fill + kac_pkg::FILL_BITS'(1);
        end
    end

endmodule

>>> src/k_times_admission_counter.sv
// Top level of the K-times admission counter.
//
//   channel  | signals                     | accepted when
//   ---------+-----------------------------+----------------------------
//   input    | i_valid, o_ready, i_item    | i_valid && o_ready
//   result   | o_valid, i_ready, o_item    | o_valid && i_ready
//   config   | i_cfg_we, i_cfg_data        | i_cfg_we (no wait)
//
// An item passes through the input register, is matched against all
// table entries at once, and its result loads the output register at the
// same edge that updates the table: one item per cycle while results are
// taken, and the result is offered from the output register once it is
// loaded there. Reset empties the table and sets k_times to 2. A stalled
// result holds one item in the input register; o_ready falls only when
// both registers are full and i_ready is low.
module k_times_admission_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  kac_pkg::t_in_item             i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output kac_pkg::t_out_item            o_item,
    input  logic                          i_cfg_we,
    input  logic [kac_pkg::COUNT_BITS-1:0] i_cfg_data
);

    logic                           r_in_valid;
    kac_pkg::t_in_item              r_in;
    logic                           r_out_valid;
    kac_pkg::t_out_item             r_out;
    kac_pkg::t_out_item             n_out;
    logic [kac_pkg::COUNT_BITS-1:0] r_k_times;
    logic                           advance;
    kac_pkg::t_key                  key;
    kac_pkg::t_lookup               res;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    assign key = '{hash: r_in.desc_hash, desc: kac_pkg::desc_key(r_in.desc_id)};

    kac_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_key   (key),
        .o_res   (res)
    );

    always_comb begin
        if (res.hit) begin
            n_out = '{reached_k: (res.count >= r_k_times), was_new: 1'b0,
                      table_full: 1'b0, sightings: res.count};
        end else if (res.full) begin
            n_out = '{reached_k: 1'b0, was_new: 1'b1, table_full: 1'b1,
                      sightings: '0};
        end else begin
            n_out = '{reached_k: 1'b0, was_new: 1'b1, table_full: 1'b0,
                      sightings: kac_pkg::COUNT_ONE};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_k_times   <= kac_pkg::K_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_k_times <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

>>> src/kac_checker.sv
// Port-level checker for the K-times admission counter, with its bind.
`include "k_times_admission_counter_assert.svh"

module kac_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input kac_pkg::t_out_item o_item
);

    // A result that is not taken stays offered.
    `KTAC_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    // A full table can only turn away a new pair.
    `KTAC_ASSERT_IMP(a_full_new, i_clk, i_rst_n, o_valid && o_item.table_full, o_item.was_new && !o_item.reached_k && (o_item.sightings == '0))

    // A stored pair always has a nonzero count and is never turned away.
    `KTAC_ASSERT_IMP(a_hit_count, i_clk, i_rst_n, o_valid && !o_item.was_new, (o_item.sightings != '0) && !o_item.table_full)

    // Reset drops any pending result.
    `KTAC_ASSERT_RST(a_reset, i_clk, !i_rst_n, !o_valid)

endmodule

bind k_times_admission_counter kac_checker u_kac_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);

>>> sim/k_times_admission_counter_tb.sv
// Self-checking testbench for the K-times admission counter with a table-based predictor.
module k_times_admission_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 40;
    localparam int PHASE_ITEMS   = 240;
    localparam int REPEAT_ITEMS  = 100;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    kac_pkg::t_in_item              i_item;
    logic                           o_valid;
    logic                           i_ready;
    kac_pkg::t_out_item             o_item;
    logic                           i_cfg_we;
    logic [kac_pkg::COUNT_BITS-1:0] i_cfg_data;

    // Predicted contents of the sighting table; entries fill in index order.
    logic [63:0]                    seen_hash  [kac_pkg::ENTRIES];
    logic [kac_pkg::DESC_BITS-1:0]  seen_desc  [kac_pkg::ENTRIES];
    logic [kac_pkg::COUNT_BITS-1:0] seen_count [kac_pkg::ENTRIES];
    int                             seen_fill = 0;
    logic [kac_pkg::COUNT_BITS-1:0] k_admit   = kac_pkg::K_RESET;

    kac_pkg::t_out_item pending_verdicts[$];
    int                 mismatches   = 0;
    int                 feed_gap_max = 15;
    int                 sink_gap_max = 15;
    int                 sink_hold    = 0;
    int                 quiet_cycles = 0;

    k_times_admission_counter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic kac_pkg::t_out_item predict_sighting(input kac_pkg::t_in_item s);
        logic [kac_pkg::DESC_BITS-1:0] d;
        kac_pkg::t_out_item            v;
        logic                          found;
        d     = kac_pkg::DESC_BITS'(s.desc_id);
        v     = '0;
        found = 1'b0;
        for (int n = 0; n < seen_fill; n++) begin
            if (!found && seen_hash[n] == s.desc_hash && seen_desc[n] == d) begin
                found = 1'b1;
                if (seen_count[n] != kac_pkg::COUNT_MAX) begin
                    seen_count[n] = seen_count[n] + kac_pkg::COUNT_ONE;
                end
                v.sightings = seen_count[n];
                v.reached_k = (seen_count[n] >= k_admit);
            end
        end
        if (!found) begin
            v.was_new = 1'b1;
            if (seen_fill < kac_pkg::ENTRIES) begin
                seen_hash[seen_fill]  = s.desc_hash;
                seen_desc[seen_fill]  = d;
                seen_count[seen_fill] = kac_pkg::COUNT_ONE;
                seen_fill++;
                v.sightings = kac_pkg::COUNT_ONE;
            end else begin
                v.table_full = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic kac_pkg::t_in_item sighting_of(input logic [63:0] h,
                                                      input logic [31:0] d);
        kac_pkg::t_in_item s;
        s.desc_hash = h;
        s.desc_id   = d;
        return s;
    endfunction

    // Mostly repeats of stored pairs, some one-bit near misses, the rest fresh pairs.
    function automatic kac_pkg::t_in_item pick_sighting();
        kac_pkg::t_in_item s;
        int                r;
        int                n;
        int                b;
        r = $urandom_range(0, 99);
        if (seen_fill > 0 && r < 65) begin
            n = $urandom_range(0, seen_fill - 1);
            s.desc_hash = seen_hash[n];
            s.desc_id   = 32'(seen_desc[n]);
            if (r >= 55) begin
                b = $urandom_range(0, 95);
                if (b < 64) begin
                    s.desc_hash[b] = ~s.desc_hash[b];
                end else begin
                    s.desc_id[b-64] = ~s.desc_id[b-64];
                end
            end
        end else begin
            s.desc_hash = {$urandom, $urandom};
            s.desc_id   = $urandom;
        end
        return s;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic offer_sighting(input kac_pkg::t_in_item s);
        int gap;
        gap = $urandom_range(0, feed_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= s;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_verdicts.push_back(predict_sighting(s));
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_k_times(input logic [kac_pkg::COUNT_BITS-1:0] value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        k_admit = value;
    endtask

    task automatic test_directed();
        offer_sighting(sighting_of('0, '0));
        offer_sighting(sighting_of('0, '0));
        offer_sighting(sighting_of('1, '1));
        offer_sighting(sighting_of('1, '1));
        offer_sighting(sighting_of('0, '1));
        offer_sighting(sighting_of('1, '0));
        offer_sighting(sighting_of('0, '0));
        // With k_times at one a new pair still does not count as admitted.
        write_k_times(kac_pkg::COUNT_BITS'(1));
        offer_sighting(sighting_of(64'h8000_0000_0000_0000, 32'h8000_0000));
        offer_sighting(sighting_of(64'h8000_0000_0000_0000, 32'h8000_0000));
        // Zero is out of range but legal to write: every hit is admitted.
        write_k_times('0);
        offer_sighting(sighting_of('0, '0));
        offer_sighting(sighting_of(64'h1, 32'h1));
        offer_sighting(sighting_of(64'h1, 32'h1));
        write_k_times(kac_pkg::COUNT_MAX);
        offer_sighting(sighting_of('1, '1));
    endtask

    // One pair seen again and again, with no idling on either side.
    task automatic test_repeats();
        kac_pkg::t_in_item pair;
        pair = sighting_of({$urandom, $urandom}, $urandom);
        feed_gap_max = 0;
        sink_gap_max = 0;
        repeat (REPEAT_ITEMS) offer_sighting(pair);
        settle();
        feed_gap_max = 15;
        sink_gap_max = 15;
    endtask

    task automatic test_random();
        logic [kac_pkg::COUNT_BITS-1:0] k_plan [5];
        k_plan = '{kac_pkg::COUNT_BITS'(1), kac_pkg::COUNT_BITS'(3),
                   kac_pkg::COUNT_BITS'($urandom_range(4, 20)), '0, kac_pkg::COUNT_MAX};
        for (int p = 0; p < 5; p++) begin
            write_k_times(k_plan[p]);
            if (p == 2) begin
                feed_gap_max = 0;
                sink_gap_max = 0;
            end
            repeat (PHASE_ITEMS) offer_sighting(pick_sighting());
            feed_gap_max = 15;
            sink_gap_max = 15;
        end
    endtask

    task automatic test_backpressure();
        write_k_times(kac_pkg::COUNT_BITS'(4));
        sink_hold    = HOLD_CYCLES;
        feed_gap_max = 0;
        repeat (30) offer_sighting(pick_sighting());
        feed_gap_max = 15;
        // The sender waits here until every outstanding result is back.
        settle();
        repeat (20) offer_sighting(pick_sighting());
    endtask

    initial begin : result_sink
        int gap;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = $urandom_range(0, sink_gap_max) + sink_hold;
            sink_hold = 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : verdict_check
        kac_pkg::t_out_item want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                $error("result with no item outstanding: %p", o_item);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_item.reached_k !== want.reached_k) begin
                    $error("reached_k: expected %0d, got %0d", want.reached_k, o_item.reached_k);
                    mismatches++;
                end
                if (o_item.was_new !== want.was_new) begin
                    $error("was_new: expected %0d, got %0d", want.was_new, o_item.was_new);
                    mismatches++;
                end
                if (o_item.table_full !== want.table_full) begin
                    $error("table_full: expected %0d, got %0d",
                           want.table_full, o_item.table_full);
                    mismatches++;
                end
                if (o_item.sightings !== want.sightings) begin
                    $error("sightings: expected %0d, got %0d", want.sightings, o_item.sightings);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : stall_watch
        if ((i_valid === 1'b1 && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("k_times_admission_counter_tb: FAIL");
            $finish;
        end
    end

    initial begin : run
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_repeats();
        test_random();
        test_backpressure();
        settle();
        if (mismatches == 0) begin
            $display("k_times_admission_counter_tb: PASS");
        end else begin
            $display("k_times_admission_counter_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> k_times_admission_counter.f
+incdir+src
src/kac_pkg.sv
src/kac_entry.sv
src/kac_lookup.sv
src/k_times_admission_counter.sv
src/kac_checker.sv
sim/k_times_admission_counter_tb.sv
